// File: hdl/afgr_pkg.sv
package afgr_pkg;

  // Gain and sample formats
  localparam int GAIN_FRAC_BITS = 24;
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int MS_W    = 14;
  localparam int RATE_W  = 18;
  localparam int PROD_W  = MS_W + RATE_W;
  localparam int LEN_W   = 23;            // floor((2^32 - 1) / 1000) fits in 23 bits
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam int MS_PER_S = 1000;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [MS_W-1:0]   MS_RESET   = MS_W'(50);

  // Beat layouts
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + MS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * SAMPLE_BITS + GAIN_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Iteration counter covers the longest serial pass
  localparam int MAX_A     = (PROD_W > GAIN_W) ? PROD_W : GAIN_W;
  localparam int MAX_STEPS = (MAX_A > SAMPLE_BITS) ? MAX_A : SAMPLE_BITS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  // Serial product register of one channel
  localparam int SPROD_W = SAMPLE_BITS + GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MS  = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_FADE_OUT = 2'd1,
    CMD_FADE_IN  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_MS,
    ST_DIV_K,
    ST_DIV_STEP,
    ST_SCALE,
    ST_FINISH
  } state_t;

endpackage

// File: hdl/audio_fade_gain_ramp.sv
// Stereo linear fade-in / fade-out gain ramp.
// Input beats arrive on in_tvalid/in_tready; in_tuser carries the command
// (audio sample, start fade out, start fade in) and in_tdata the two samples
// and the fade duration. Each audio sample beat yields one result beat on
// out_tvalid/out_tready; start commands and unknown commands yield none.
// Registers (sample rate, default duration) are written on the cfg_ channel,
// which is always ready; write them only while the block is idle.
// An audio sample passes from acceptance to the result being held in the
// output register through one bit-serial multiply pass over the sample
// magnitude (both channels side by side) and a step that rounds the products
// and steps the gain. A start command occupies the block for a shift-add
// product of duration and rate, a restoring division by 1000 and a restoring
// division of unity by the ramp length, the two divisions sharing one
// remainder register and subtractor.
// in_tready is high only while no item is being worked on. A finished result
// waits in the output register, so the next item is accepted while the
// receiver stalls; a second result waits until the first beat has gone.
// After reset the gain is unity, no fade runs, the sample rate is 48000 Hz
// and the default duration 50 ms.
module audio_fade_gain_ramp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // left_sample [23:0], right_sample [47:24], duration_ms [61:48], zero pad
  input  logic [afgr_pkg::IN_TDATA_W-1:0]        in_tdata,
  // command [1:0]
  input  logic [afgr_pkg::CMD_W-1:0]             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // left_out [23:0], right_out [47:24], gain_now [72:48], fade_active [73],
  // zero pad
  output logic [afgr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [afgr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [afgr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import afgr_pkg::*;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic [MS_W-1:0]        dflt_ms_r, dflt_ms_nxt;
  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [GAIN_W-1:0]      step_r, step_nxt;
  logic                   falling_r, falling_nxt;
  logic                   active_r, active_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PROD_W-1:0]      p_r, p_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [GAIN_W-1:0]      dq_r, dq_nxt;
  logic [SPROD_W-1:0]     pl_r, pl_nxt;
  logic [SPROD_W-1:0]     pr_r, pr_nxt;
  logic                   negl_r, negl_nxt;
  logic                   negr_r, negr_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_FIELDS_W-1:0] out_data_r, out_data_nxt;

  logic                   in_acc;
  logic                   out_free;
  cmd_t                   cmd;
  logic [SAMPLE_BITS-1:0] in_left, in_right;
  logic [MS_W-1:0]        in_ms;

  // Shared restoring divider
  logic                   div_bit;
  logic [LEN_W:0]         div_trial;
  logic [LEN_W:0]         div_divisor;
  logic [LEN_W:0]         div_diff;
  logic                   div_q;

  // Shift-add helpers
  logic [RATE_W:0]        ms_sum;
  logic [GAIN_W:0]        l_sum, r_sum;

  // Rounding of the finished products
  logic [SAMPLE_BITS-1:0] l_q, r_q, l_tmp, r_tmp, l_res, r_res;
  logic                   l_sticky, r_sticky;
  logic [GAIN_W:0]        gain_up;

  logic [PROD_W-1:0]      k_quot;
  logic [GAIN_W-1:0]      s_quot;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_r};

  assign cmd      = cmd_t'(in_tuser);
  assign in_left  = in_tdata[SAMPLE_BITS-1:0];
  assign in_right = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_ms    = in_tdata[2*SAMPLE_BITS+MS_W-1:2*SAMPLE_BITS];

  // The remainder stays below the divisor, so it always fits in LEN_W bits.
  assign div_bit     = (state_r == ST_DIV_K) ? p_r[PROD_W-1] : dq_r[GAIN_W-1];
  assign div_divisor = (state_r == ST_DIV_K) ? (LEN_W+1)'(MS_PER_S) : {1'b0, len_r};
  assign div_trial   = {rem_r, div_bit};
  assign div_diff    = div_trial - div_divisor;
  assign div_q       = (div_trial >= div_divisor);

  assign k_quot = {p_r[PROD_W-2:0], div_q};
  assign s_quot = {dq_r[GAIN_W-2:0], div_q};

  assign ms_sum = {1'b0, p_r[PROD_W-1:MS_W]} + (p_r[0] ? {1'b0, rate_r} : '0);
  assign l_sum  = {1'b0, pl_r[SPROD_W-1:SAMPLE_BITS]} + (pl_r[0] ? {1'b0, gain_r} : '0);
  assign r_sum  = {1'b0, pr_r[SPROD_W-1:SAMPLE_BITS]} + (pr_r[0] ? {1'b0, gain_r} : '0);

  // A negative product rounds towards minus infinity, so any set fraction bit
  // adds one to the magnitude before it is negated.
  assign l_q      = pl_r[GAIN_FRAC_BITS +: SAMPLE_BITS];
  assign r_q      = pr_r[GAIN_FRAC_BITS +: SAMPLE_BITS];
  assign l_sticky = |pl_r[GAIN_FRAC_BITS-1:0];
  assign r_sticky = |pr_r[GAIN_FRAC_BITS-1:0];
  assign l_tmp    = l_q + {{(SAMPLE_BITS-1){1'b0}}, l_sticky};
  assign r_tmp    = r_q + {{(SAMPLE_BITS-1){1'b0}}, r_sticky};
  assign l_res    = negl_r ? (SAMPLE_BITS'(0) - l_tmp) : l_q;
  assign r_res    = negr_r ? (SAMPLE_BITS'(0) - r_tmp) : r_q;
  assign gain_up  = {1'b0, gain_r} + {1'b0, step_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_SAMPLE:   state_nxt = ST_SCALE;
            CMD_FADE_OUT: state_nxt = ST_MUL_MS;
            CMD_FADE_IN:  state_nxt = ST_MUL_MS;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL_MS:   if (cnt_r == '0) state_nxt = ST_DIV_K;
      ST_DIV_K:    if (cnt_r == '0) state_nxt = ST_DIV_STEP;
      ST_DIV_STEP: if (cnt_r == '0) state_nxt = ST_IDLE;
      ST_SCALE:    if (cnt_r == '0) state_nxt = ST_FINISH;
      ST_FINISH:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rate_nxt      = rate_r;
    dflt_ms_nxt   = dflt_ms_r;
    gain_nxt      = gain_r;
    step_nxt      = step_r;
    falling_nxt   = falling_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r - CNT_W'(1);
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    dq_nxt        = dq_r;
    pl_nxt        = pl_r;
    pr_nxt        = pr_r;
    negl_nxt      = negl_r;
    negr_nxt      = negr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SAMPLE_RATE) begin
        rate_nxt = cfg_data;
      end else if (cfg_index == REG_DEFAULT_MS) begin
        dflt_ms_nxt = cfg_data[MS_W-1:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_SAMPLE: begin
              negl_nxt = in_left[SAMPLE_BITS-1];
              negr_nxt = in_right[SAMPLE_BITS-1];
              pl_nxt   = {{GAIN_W{1'b0}},
                          in_left[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - in_left) : in_left};
              pr_nxt   = {{GAIN_W{1'b0}},
                          in_right[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - in_right) : in_right};
              cnt_nxt  = CNT_W'(SAMPLE_BITS - 1);
            end
            CMD_FADE_OUT, CMD_FADE_IN: begin
              p_nxt       = {{RATE_W{1'b0}}, (in_ms == '0) ? dflt_ms_r : in_ms};
              falling_nxt = (cmd == CMD_FADE_OUT);
              active_nxt  = 1'b1;
              cnt_nxt     = CNT_W'(MS_W - 1);
            end
            default: ;
          endcase
        end
      end
      ST_MUL_MS: begin
        // Multiplier bits leave at the bottom while partial sums enter on top.
        p_nxt = {ms_sum, p_r[MS_W-1:1]};
        if (cnt_r == '0) begin
          rem_nxt = '0;
          cnt_nxt = CNT_W'(PROD_W - 1);
        end
      end
      ST_DIV_K: begin
        p_nxt   = k_quot;
        rem_nxt = div_q ? div_diff[LEN_W-1:0] : div_trial[LEN_W-1:0];
        if (cnt_r == '0) begin
          len_nxt = (k_quot[LEN_W-1:0] == '0) ? LEN_W'(1) : k_quot[LEN_W-1:0];
          rem_nxt = '0;
          dq_nxt  = UNITY_GAIN;
          cnt_nxt = CNT_W'(GAIN_W - 1);
        end
      end
      ST_DIV_STEP: begin
        dq_nxt  = s_quot;
        rem_nxt = div_q ? div_diff[LEN_W-1:0] : div_trial[LEN_W-1:0];
        if (cnt_r == '0) begin
          step_nxt = (s_quot == '0) ? GAIN_W'(1) : s_quot;
        end
      end
      ST_SCALE: begin
        pl_nxt = {l_sum, pl_r[SAMPLE_BITS-1:1]};
        pr_nxt = {r_sum, pr_r[SAMPLE_BITS-1:1]};
      end
      ST_FINISH: begin
        if (out_free) begin
          if (active_r) begin
            if (falling_r) begin
              if (gain_r <= step_r) begin
                gain_nxt   = '0;
                active_nxt = 1'b0;
              end else begin
                gain_nxt = gain_r - step_r;
              end
            end else begin
              if (gain_up >= {1'b0, UNITY_GAIN}) begin
                gain_nxt   = UNITY_GAIN;
                active_nxt = 1'b0;
              end else begin
                gain_nxt = gain_up[GAIN_W-1:0];
              end
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {active_nxt, gain_nxt, r_res, l_res};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= RATE_RESET;
      dflt_ms_r   <= MS_RESET;
      gain_r      <= UNITY_GAIN;
      step_r      <= '0;
      falling_r   <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      dflt_ms_r   <= dflt_ms_nxt;
      gain_r      <= gain_nxt;
      step_r      <= step_nxt;
      falling_r   <= falling_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    p_r        <= p_nxt;
    rem_r      <= rem_nxt;
    len_r      <= len_nxt;
    dq_r       <= dq_nxt;
    pl_r       <= pl_nxt;
    pr_r       <= pr_nxt;
    negl_r     <= negl_nxt;
    negr_r     <= negr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
